// ----- rtl/dps_pkg.sv -----
// ----------------------------------------------------------------------------
// dps_pkg
// Shared types, opcodes, branch conditions and the microcode ROM of the
// divisor power sum engine.
// ----------------------------------------------------------------------------
package dps_pkg;

   localparam int UPC_BITS = 4;
   typedef logic [UPC_BITS-1:0] upc_type;

   // Datapath operations
   typedef logic [3:0] op_type;
   localparam op_type OP_NOP      = 4'd0;
   localparam op_type OP_LOAD     = 4'd1;
   localparam op_type OP_DIV_INIT = 4'd2;
   localparam op_type OP_DIV_STEP = 4'd3;
   localparam op_type OP_POW_INIT = 4'd4;
   localparam op_type OP_MUL_LO   = 4'd5;
   localparam op_type OP_MUL_HI   = 4'd6;
   localparam op_type OP_MUL_CHK  = 4'd7;
   localparam op_type OP_ADD      = 4'd8;
   localparam op_type OP_INC      = 4'd9;
   localparam op_type OP_EMIT     = 4'd10;

   // Branch conditions
   typedef logic [3:0] cond_type;
   localparam cond_type C_NEVER    = 4'd0;
   localparam cond_type C_ALWAYS   = 4'd1;
   localparam cond_type C_NO_REQ   = 4'd2;
   localparam cond_type C_N_ZERO   = 4'd3;
   localparam cond_type C_DIV_MORE = 4'd4;
   localparam cond_type C_SKIP     = 4'd5;
   localparam cond_type C_E_ZERO   = 4'd6;
   localparam cond_type C_POW_OVER = 4'd7;
   localparam cond_type C_D_LAST   = 4'd8;
   localparam cond_type C_OUT_BUSY = 4'd9;

   // Microprogram addresses
   localparam upc_type UA_WAIT  = 4'd0;
   localparam upc_type UA_CHKZ  = 4'd1;
   localparam upc_type UA_DIVI  = 4'd2;
   localparam upc_type UA_DIVS  = 4'd3;
   localparam upc_type UA_TEST  = 4'd4;
   localparam upc_type UA_POWI  = 4'd5;
   localparam upc_type UA_POWT  = 4'd6;
   localparam upc_type UA_MULL  = 4'd7;
   localparam upc_type UA_MULH  = 4'd8;
   localparam upc_type UA_MULC  = 4'd9;
   localparam upc_type UA_LOOP  = 4'd10;
   localparam upc_type UA_ADD   = 4'd11;
   localparam upc_type UA_NEXT  = 4'd12;
   localparam upc_type UA_AGAIN = 4'd13;
   localparam upc_type UA_EMIT  = 4'd14;
   localparam upc_type UA_RET   = 4'd15;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      upc_type  target;
   } uword_type;

   // Datapath flags seen by the branch logic
   typedef struct packed {
      logic n_zero;
      logic div_more;
      logic skip;
      logic e_zero;
      logic pow_over;
      logic d_last;
      logic out_busy;
   } dstat_type;

   function automatic uword_type ucode_rom(input upc_type pc);
      uword_type w;
      case (pc)
         UA_WAIT:  w = '{OP_LOAD,     C_NO_REQ,   UA_WAIT};
         UA_CHKZ:  w = '{OP_NOP,      C_N_ZERO,   UA_EMIT};
         UA_DIVI:  w = '{OP_DIV_INIT, C_NEVER,    UA_WAIT};
         UA_DIVS:  w = '{OP_DIV_STEP, C_DIV_MORE, UA_DIVS};
         UA_TEST:  w = '{OP_NOP,      C_SKIP,     UA_NEXT};
         UA_POWI:  w = '{OP_POW_INIT, C_NEVER,    UA_WAIT};
         UA_POWT:  w = '{OP_NOP,      C_E_ZERO,   UA_ADD};
         UA_MULL:  w = '{OP_MUL_LO,   C_NEVER,    UA_WAIT};
         UA_MULH:  w = '{OP_MUL_HI,   C_NEVER,    UA_WAIT};
         UA_MULC:  w = '{OP_MUL_CHK,  C_POW_OVER, UA_NEXT};
         UA_LOOP:  w = '{OP_NOP,      C_ALWAYS,   UA_POWT};
         UA_ADD:   w = '{OP_ADD,      C_NEVER,    UA_WAIT};
         UA_NEXT:  w = '{OP_INC,      C_D_LAST,   UA_EMIT};
         UA_AGAIN: w = '{OP_NOP,      C_ALWAYS,   UA_DIVI};
         UA_EMIT:  w = '{OP_EMIT,     C_OUT_BUSY, UA_EMIT};
         UA_RET:   w = '{OP_NOP,      C_ALWAYS,   UA_WAIT};
         default:  w = '{OP_NOP,      C_ALWAYS,   UA_WAIT};
      endcase
      return w;
   endfunction

endpackage

// ----- rtl/dps_sequencer.sv -----
// ----------------------------------------------------------------------------
// dps_sequencer
// Microprogram counter, ROM fetch and conditional branch selection.
// ----------------------------------------------------------------------------
module dps_sequencer
   import dps_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   input  dstat_type dstat,
   output op_type    op,
   output logic      req_ready
);

   upc_type   pc_ff;
   upc_type   pc_in;
   uword_type uword;
   logic      taken;

   assign uword     = ucode_rom(pc_ff);
   assign op        = uword.op;
   assign req_ready = (uword.op == OP_LOAD);

   always_comb begin
      case (uword.cond)
         C_NEVER:    taken = 1'b0;
         C_ALWAYS:   taken = 1'b1;
         C_NO_REQ:   taken = !req_valid;
         C_N_ZERO:   taken = dstat.n_zero;
         C_DIV_MORE: taken = dstat.div_more;
         C_SKIP:     taken = dstat.skip;
         C_E_ZERO:   taken = dstat.e_zero;
         C_POW_OVER: taken = dstat.pow_over;
         C_D_LAST:   taken = dstat.d_last;
         C_OUT_BUSY: taken = dstat.out_busy;
         default:    taken = 1'b1;
      endcase
      pc_in = taken ? uword.target : pc_ff + upc_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= UA_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ----- rtl/dps_datapath.sv -----
// ----------------------------------------------------------------------------
// dps_datapath
// Working registers, restoring remainder step, split power multiply,
// saturating accumulator and the result register.
// ----------------------------------------------------------------------------
module dps_datapath
   import dps_pkg::*;
#(
   parameter int NUMBER_BITS = 16,
   parameter int SUM_BITS    = 63
) (
   input  logic                   clock,
   input  logic                   reset,
   input  op_type                 op,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [NUMBER_BITS-1:0] req_number,
   input  logic [2:0]             exponent,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [SUM_BITS-1:0]    rsp_power_sum,
   output logic                   rsp_overflowed,
   output dstat_type              dstat
);

   localparam int CNT_W  = $clog2(NUMBER_BITS);
   localparam int HALF_W = 32 + NUMBER_BITS;
   localparam int PROD_W = 64 + NUMBER_BITS + 1;
   localparam logic [SUM_BITS-1:0] LIM = {SUM_BITS{1'b1}};
   // A full 64-bit sum still reports only its low 63 bits
   localparam logic [SUM_BITS-1:0] OUT_MASK = (SUM_BITS == 64) ? (LIM >> 1) : LIM;

   logic [NUMBER_BITS-1:0] n_ff, n_in;
   logic [NUMBER_BITS-1:0] d_ff, d_in;
   logic [NUMBER_BITS-1:0] rem_ff, rem_in;
   logic [NUMBER_BITS-1:0] div_ff, div_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [SUM_BITS-1:0]    p_ff, p_in;
   logic [2:0]             e_ff, e_in;
   logic [HALF_W-1:0]      lo_ff, lo_in;
   logic [HALF_W-1:0]      hi_ff, hi_in;
   logic [SUM_BITS-1:0]    acc_ff, acc_in;
   logic                   sat_ff, sat_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SUM_BITS-1:0]    rsp_sum_ff, rsp_sum_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   logic [NUMBER_BITS:0]   rem_sh;
   logic [63:0]            p_ext;
   logic [PROD_W-1:0]      prod;
   logic                   prod_over;
   logic [SUM_BITS:0]      add_sum;
   logic                   out_busy;

   assign rem_sh    = {rem_ff, div_ff[NUMBER_BITS-1]};
   assign p_ext     = 64'(p_ff);
   assign prod      = (PROD_W'(hi_ff) << 32) + PROD_W'(lo_ff);
   assign prod_over = |prod[PROD_W-1:SUM_BITS];
   assign add_sum   = {1'b0, acc_ff} + {1'b0, p_ff};
   assign out_busy  = rsp_valid_ff && !rsp_ready;

   assign dstat.n_zero   = (n_ff == '0);
   assign dstat.div_more = (cnt_ff != '0);
   assign dstat.skip     = (rem_ff != '0) || sat_ff;
   assign dstat.e_zero   = (e_ff == '0);
   assign dstat.pow_over = prod_over;
   assign dstat.d_last   = (d_ff == n_ff);
   assign dstat.out_busy = out_busy;

   always_comb begin
      n_in       = n_ff;
      d_in       = d_ff;
      rem_in     = rem_ff;
      div_in     = div_ff;
      cnt_in     = cnt_ff;
      p_in       = p_ff;
      e_in       = e_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      acc_in     = acc_ff;
      sat_in     = sat_ff;
      rsp_sum_in = rsp_sum_ff;
      rsp_ovf_in = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (op)
         OP_LOAD: begin
            if (req_valid && req_ready) begin
               n_in   = req_number;
               d_in   = NUMBER_BITS'(1);
               acc_in = '0;
               sat_in = 1'b0;
            end
         end
         OP_DIV_INIT: begin
            rem_in = '0;
            div_in = n_ff;
            cnt_in = CNT_W'(NUMBER_BITS - 1);
         end
         OP_DIV_STEP: begin
            // restoring step: shift in the next dividend bit, subtract if it fits
            if (rem_sh >= {1'b0, d_ff}) begin
               rem_in = NUMBER_BITS'(rem_sh - {1'b0, d_ff});
            end else begin
               rem_in = rem_sh[NUMBER_BITS-1:0];
            end
            div_in = div_ff << 1;
            cnt_in = cnt_ff - CNT_W'(1);
         end
         OP_POW_INIT: begin
            p_in = SUM_BITS'(1);
            e_in = exponent;
         end
         OP_MUL_LO: begin
            lo_in = HALF_W'(p_ext[31:0]) * HALF_W'(d_ff);
         end
         OP_MUL_HI: begin
            hi_in = HALF_W'(p_ext[63:32]) * HALF_W'(d_ff);
         end
         OP_MUL_CHK: begin
            if (prod_over) begin
               acc_in = LIM;
               sat_in = 1'b1;
            end else begin
               p_in = prod[SUM_BITS-1:0];
               e_in = e_ff - 3'd1;
            end
         end
         OP_ADD: begin
            if (add_sum[SUM_BITS]) begin
               acc_in = LIM;
               sat_in = 1'b1;
            end else begin
               acc_in = add_sum[SUM_BITS-1:0];
            end
         end
         OP_INC: begin
            d_in = d_ff + NUMBER_BITS'(1);
         end
         OP_EMIT: begin
            // hold the result until the previous one is transferred
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = acc_ff & OUT_MASK;
               rsp_ovf_in   = sat_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      d_ff       <= d_in;
      rem_ff     <= rem_in;
      div_ff     <= div_in;
      cnt_ff     <= cnt_in;
      p_ff       <= p_in;
      e_ff       <= e_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      acc_ff     <= acc_in;
      sat_ff     <= sat_in;
      rsp_sum_ff <= rsp_sum_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_power_sum  = rsp_sum_ff;
   assign rsp_overflowed = rsp_ovf_ff;

endmodule

// ----- rtl/divisor_power_sum.sv -----
// ----------------------------------------------------------------------------
// divisor_power_sum
// Divisor sigma engine: power_sum = sum of d^exponent over all divisors d
// of number, saturating at the largest SUM_BITS-bit value.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one number per transfer; taken only while the engine is idle.
//   rsp_*  : one result per number, held in an output register until taken.
//   csr_*  : exponent write (3 bits), always ready; write while idle.
// Exponent zero counts the divisors; number zero returns zero.
// Overflow saturates power_sum at its maximum and sets rsp_overflowed.
// The engine runs a microcoded loop over candidates d = 1..n, each needing
// a bit-serial restoring remainder over the NUMBER_BITS dividend bits;
// each divisor d is then raised to the exponent by repeated multiplication
// before it is added. Number zero skips the loop.
// A result that is not taken stalls the engine at its final step; the next
// number is accepted once that result is parked in the output register.
// Reset clears the sequencer, drops any pending result and sets exponent 0.
// ----------------------------------------------------------------------------
module divisor_power_sum
   import dps_pkg::*;
#(
   parameter int NUMBER_BITS = 16,
   parameter int SUM_BITS    = 63
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [NUMBER_BITS-1:0] req_number,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SUM_BITS-1:0]    rsp_power_sum,
   output logic                   rsp_overflowed,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [2:0]             csr_exponent
);

   logic [2:0] exponent_ff;
   op_type     op;
   dstat_type  dstat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_ff <= 3'd0;
      end else if (csr_valid && csr_ready) begin
         exponent_ff <= csr_exponent;
      end
   end

   dps_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .dstat     (dstat),
      .op        (op),
      .req_ready (req_ready)
   );

   dps_datapath #(
      .NUMBER_BITS (NUMBER_BITS),
      .SUM_BITS    (SUM_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .op             (op),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_number     (req_number),
      .exponent       (exponent_ff),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_power_sum  (rsp_power_sum),
      .rsp_overflowed (rsp_overflowed),
      .dstat          (dstat)
   );

endmodule

// ----- rtl/dps_checker.sv -----
// ----------------------------------------------------------------------------
// dps_checker
// Port-level checks of the divisor power sum engine, bound to the top level.
// ----------------------------------------------------------------------------
module dps_checker #(
   parameter int NUMBER_BITS = 16,
   parameter int SUM_BITS    = 63
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SUM_BITS-1:0]    rsp_power_sum,
   input logic                   rsp_overflowed
);

   localparam logic [SUM_BITS-1:0] LIM = {SUM_BITS{1'b1}};
   localparam logic [SUM_BITS-1:0] OUT_MAX = (SUM_BITS == 64) ? (LIM >> 1) : LIM;

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_power_sum)
         && $stable(rsp_overflowed))
      else $error("result changed while stalled");

   // an overflowed result is pinned at the saturation value
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflowed |-> rsp_power_sum == OUT_MAX)
      else $error("overflow flagged without saturated sum");

   // the engine is busy right after taking a number
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second number taken back to back");

   // no result can appear in the cycle after a number is taken
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result raised too early");

   // reset drops any pending result
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind divisor_power_sum dps_checker #(
   .NUMBER_BITS (NUMBER_BITS),
   .SUM_BITS    (SUM_BITS)
) u_dps_checker (.*);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// divisor_power_sum testbench
// Drives numbers and exponent writes into the divisor sigma engine with
// random idle gaps on both channels. A scoreboard class computes
// sigma_exponent(number) with saturation for every accepted number and
// compares each returned result, in order, field by field.
// ----------------------------------------------------------------------------
module testbench;

   localparam int NUMBER_BITS = 16;
   localparam int SUM_BITS    = 63;
   // long enough to cover two of the largest random numbers
   localparam int HOLD_CYCLES = 100000;
   localparam int DRAIN_CYCLES = 100;
   // sized to outlast one number of 65535 at exponent 7 on its own
   localparam int STALL_LIMIT = 4000000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS = 14;

   typedef struct packed {
      bit [SUM_BITS-1:0] power_sum;
      bit                overflowed;
   } sigma_result_type;

   class sigma_scoreboard;
      sigma_result_type pending_sums[$];
      bit [2:0]         exponent;
      int               mismatches;

      function new();
         exponent = 3'd0;
         mismatches = 0;
      endfunction

      function void set_exponent(bit [2:0] e);
         exponent = e;
      endfunction

      // sum of d^exponent over the divisors of n, saturating at the top value
      function sigma_result_type divisor_sigma(bit [NUMBER_BITS-1:0] n);
         bit [63:0]        lim;
         bit [63:0]        acc;
         bit [63:0]        p;
         bit               sat;
         int unsigned      d;
         int unsigned      k;
         sigma_result_type r;
         lim = {64{1'b1}} >> (64 - SUM_BITS);
         acc = 0;
         sat = 0;
         for (d = 1; d <= n; d++) begin
            if ((n % d) != 0 || sat)
               continue;
            p = 1;
            for (k = 0; k < exponent; k++) begin
               if (p > lim / d) begin
                  sat = 1;
                  break;
               end
               p = p * d;
            end
            if (sat)
               acc = lim;
            else if (acc > lim - p) begin
               acc = lim;
               sat = 1;
            end else
               acc = acc + p;
         end
         r.power_sum = acc[SUM_BITS-1:0];
         r.overflowed = sat;
         return r;
      endfunction

      function void note_number(bit [NUMBER_BITS-1:0] n);
         pending_sums.push_back(divisor_sigma(n));
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("MISMATCH at %0t: %s", $realtime, what);
      endtask

      task check_result(bit [SUM_BITS-1:0] power_sum, bit overflowed);
         sigma_result_type want;
         if (pending_sums.size() == 0) begin
            report_mismatch($sformatf("unexpected result power_sum=%0d overflowed=%0b",
                                      power_sum, overflowed));
            return;
         end
         want = pending_sums.pop_front();
         if (power_sum !== want.power_sum)
            report_mismatch($sformatf("power_sum got %0d want %0d",
                                      power_sum, want.power_sum));
         if (overflowed !== want.overflowed)
            report_mismatch($sformatf("overflowed got %0b want %0b",
                                      overflowed, want.overflowed));
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [NUMBER_BITS-1:0] req_number;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [SUM_BITS-1:0]    rsp_power_sum;
   logic                   rsp_overflowed;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [2:0]             csr_exponent;

   sigma_scoreboard sb = new();
   bit  no_idle = 0;
   bit  hold_request = 0;
   int  idle_cycles = 0;

   divisor_power_sum #(
      .NUMBER_BITS(NUMBER_BITS),
      .SUM_BITS(SUM_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_number(req_number),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_power_sum(rsp_power_sum),
      .rsp_overflowed(rsp_overflowed),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_exponent(csr_exponent)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (no_idle)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 200);
   endfunction

   // keep most numbers small: the engine walks every candidate up to n
   function automatic bit [NUMBER_BITS-1:0] pick_number();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return NUMBER_BITS'($urandom_range(0, 15));
      if (r < 85)
         return NUMBER_BITS'($urandom_range(16, 255));
      if (r < 97)
         return NUMBER_BITS'($urandom_range(256, 1023));
      return NUMBER_BITS'($urandom_range(1024, 2047));
   endfunction

   // called and returns at a falling edge; valid stays high for the next transfer
   task automatic send_number(input bit [NUMBER_BITS-1:0] n);
      int gap;
      gap = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1;
      req_number = n;
      do
         @(posedge clock);
      while (!req_ready);
      sb.note_number(n);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid = 0;
      while (sb.pending_sums.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_exponent(input bit [2:0] e);
      drain_results();
      csr_valid = 1;
      csr_exponent = e;
      do
         @(posedge clock);
      while (!csr_ready);
      sb.set_exponent(e);
      @(negedge clock);
      csr_valid = 0;
   endtask

   // receiver: random back-pressure plus one long hold-off on request
   initial begin
      int gap;
      int hold_left;
      rsp_ready = 0;
      gap = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ready = 0;
            hold_left--;
         end else if (gap > 0) begin
            rsp_ready = 0;
            gap--;
         end else begin
            rsp_ready = 1;
            if ($urandom_range(0, 3) == 0)
               gap = pick_gap();
         end
      end
   end

   // check results and watch for a hang
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_result(rsp_power_sum, rsp_overflowed);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
             || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      static bit [NUMBER_BITS-1:0] count_numbers [6] = '{0, 1, 2, 3, 12, 720};
      static bit [NUMBER_BITS-1:0] linear_numbers [4] = '{1, 6, 28, 97};
      static bit [NUMBER_BITS-1:0] sixth_numbers [2] = '{1446, 64};
      static bit [NUMBER_BITS-1:0] seventh_numbers [6] = '{0, 1, 511, 512, 521, 65535};
      bit [2:0] e;
      reset = 1;
      req_valid = 0;
      req_number = 0;
      csr_valid = 0;
      csr_exponent = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // exponent left at its reset value: plain divisor counts
      foreach (count_numbers[i])
         send_number(count_numbers[i]);
      write_exponent(3'd1);
      foreach (linear_numbers[i])
         send_number(linear_numbers[i]);
      // 1446^6 fits but the divisor sum does not
      write_exponent(3'd6);
      foreach (sixth_numbers[i])
         send_number(sixth_numbers[i]);
      // 512^7 and above overflow on a single power
      write_exponent(3'd7);
      foreach (seventh_numbers[i])
         send_number(seventh_numbers[i]);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph == 0)
            e = 3'd0;
         else if (ph == 1)
            e = 3'd7;
         else
            e = 3'($urandom_range(0, 7));
         write_exponent(e);
         no_idle = (ph == 3);
         if (ph == 2)
            hold_request = 1;
         for (int i = 0; i < PHASE_ITEMS; i++)
            send_number(pick_number());
      end
      no_idle = 0;

      drain_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/dps_pkg.sv
rtl/dps_sequencer.sv
rtl/dps_datapath.sv
rtl/divisor_power_sum.sv
rtl/dps_checker.sv
tb/sv/testbench.sv
